// ===== rtl/core/lbhp_pkg.sv =====
`default_nettype none
package lbhp_pkg;
    localparam int MAX_BINS_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 32;
    localparam int LOG_W    = 22;
    localparam int SCALE_W  = 32;
    localparam int NBINS_W  = 11;
    localparam int SAMPLE_W = 48;
    localparam int TF_W     = 25;
    localparam int BIN_W    = 10;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG_MIN   = 2'd0,
        CFG_BIN_SCALE = 2'd1,
        CFG_BINS_USED = 2'd2,
        CFG_SPARE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_LOG, ST_MUL_LO, ST_MUL_HI, ST_BIN, ST_RD, ST_WR,
        ST_TGT_A, ST_TGT_B, ST_SCAN, ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SAMPLE_W-1:0] sample;
    } log_req_t;

    typedef struct packed {
        logic        done;
        logic [LOG_W-1:0] value;
    } log_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/lbhp_if.sv =====
`default_nettype none
interface lbhp_in_if;
    import lbhp_pkg::*;
    logic valid;
    logic ready;
    logic [ACT_W-1:0]    action;
    logic [SAMPLE_W-1:0] sample;
    logic [TF_W-1:0]     tail_fraction;
    modport source (output valid, action, sample, tail_fraction, input ready);
    modport sink (input valid, action, sample, tail_fraction, output ready);
endinterface

interface lbhp_out_if;
    import lbhp_pkg::*;
    logic valid;
    logic ready;
    logic [BIN_W-1:0]    bin_index;
    logic                underflow_seen;
    logic                overflow_seen;
    logic [SAMPLE_W-1:0] total_count;
    modport source (output valid, bin_index, underflow_seen, overflow_seen, total_count,
        input ready);
    modport sink (input valid, bin_index, underflow_seen, overflow_seen, total_count,
        output ready);
endinterface
`default_nettype wire

// ===== rtl/core/log_binned_histogram_percentile.sv =====
// add: log unit, two 22x16 partial products, then read-modify-write of the bin count; a zero
// sample skips the log unit and the products; query: one bin read per cycle
// clear: one memory entry written per cycle, over all MAX_BINS entries; unused action: result only
// one word in flight; the next word is taken only once the result has been taken
// reset: asynchronous active low; a clearing pass over all MAX_BINS entries follows, input held off
`default_nettype none
module log_binned_histogram_percentile #(
    parameter int MAX_BINS   = lbhp_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = lbhp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lbhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbhp_pkg::CFG_DATA_W-1:0] cfg_data,
    lbhp_in_if.sink                            in_ch,
    lbhp_out_if.source                         out_ch
);
    import lbhp_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int CMAX_W = COUNT_BITS;
    localparam logic [CMAX_W-1:0] COUNT_TOP = '1;
    localparam logic [SAMPLE_W-1:0] TOTAL_TOP = '1;

    state_t state_reg, state_next;

    logic [LOG_W-1:0]   log_min_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [NBINS_W-1:0] nbins_reg;

    logic [ACT_W-1:0]    act_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TF_W-1:0]     tf_reg;
    logic [SAMPLE_W-1:0] total_reg;
    logic                low_reg, high_reg;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW:0]         sweep_reg;
    logic [AW-1:0]       bin_reg;
    logic signed [LOG_W:0] diff_reg;
    logic [48:0]         prod_reg;
    logic [72:0]         tgt_reg;
    logic [72:0]         sum_reg;
    logic                first_reg;
    logic                init_reg;

    logic                out_valid_reg;
    logic [BIN_W-1:0]    out_bin_reg;

    log_req_t lreq;
    log_rsp_t lrsp;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CMAX_W-1:0] ram_wdata;
    logic [CMAX_W-1:0] ram_rdata;
    logic [AW-1:0]     ram_raddr;

    logic [AW:0] eff_bins;
    logic [AW-1:0] top_bin;
    logic [72:0] sum_add;

    always_comb
    begin
        eff_bins = (nbins_reg == '0) ? (AW+1)'(1) :
                   ((32'(nbins_reg) > 32'(MAX_BINS)) ? (AW+1)'(MAX_BINS)
                                                     : (AW+1)'(nbins_reg));
        top_bin = AW'(eff_bins - (AW+1)'(1));
    end

    lbhp_log2 u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    lbhp_ram #(.WIDTH(CMAX_W), .DEPTH(MAX_BINS)) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ch.ready = state_reg == ST_IDLE && !out_valid_reg;
    assign lreq.start  = state_reg == ST_LOG && first_reg;
    assign lreq.sample = sample_reg;
    assign sum_add     = sum_reg + 73'(ram_rdata);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == (AW+1)'(MAX_BINS - 1))
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (action_t'(in_ch.action))
                        ACT_ADD:   state_next = (in_ch.sample == '0) ? ST_RD : ST_LOG;
                        ACT_QUERY: state_next = ST_TGT_A;
                        ACT_CLEAR: state_next = ST_SWEEP;
                        ACT_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOG:    state_next = lrsp.done ? ST_MUL_LO : ST_LOG;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_BIN;
            ST_BIN:    state_next = ST_RD;
            ST_RD:     state_next = ST_WR;
            ST_WR:     state_next = ST_DONE;
            ST_TGT_A:  state_next = ST_TGT_B;
            ST_TGT_B:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (!first_reg && (sum_add >= tgt_reg || addr_reg == '0))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = bin_reg;
        ram_wdata = (ram_rdata == COUNT_TOP) ? ram_rdata : ram_rdata + CMAX_W'(1);
        ram_raddr = bin_reg;
        addr_next = addr_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg[AW-1:0];
                ram_wdata = '0;
            end
            ST_WR:    ram_we = 1'b1;
            ST_TGT_B: addr_next = top_bin;
            ST_SCAN:
            begin
                ram_raddr = addr_reg;
                if (first_reg)
                begin
                    addr_next = addr_reg;
                end
                else if (addr_reg != '0)
                begin
                    addr_next = addr_reg - AW'(1);
                    ram_raddr = addr_reg - AW'(1);
                end
            end
            default: ram_we = 1'b0;
        endcase
    end

    // 22x32 product built from two 16-bit halves of the scale
    logic [47:0] plo, phi;
    logic [63:0] full;
    logic [31:0] bval;
    assign plo  = 48'(diff_reg[LOG_W-1:0]) * 48'(scale_reg[15:0]);
    assign phi  = 48'(diff_reg[LOG_W-1:0]) * 48'(scale_reg[31:16]);
    assign full = {15'd0, prod_reg} + {phi[47:0], 16'd0};
    assign bval = full[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            log_min_reg   <= '0;
            scale_reg     <= 32'd65536;
            nbins_reg     <= 11'd1024;
            total_reg     <= '0;
            low_reg       <= 1'b0;
            high_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            init_reg      <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LOG_MIN:   log_min_reg <= cfg_data[LOG_W-1:0];
                    CFG_BIN_SCALE: scale_reg   <= cfg_data[SCALE_W-1:0];
                    CFG_BINS_USED: nbins_reg   <= cfg_data[NBINS_W-1:0];
                    CFG_SPARE:     ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SWEEP)
            begin
                sweep_reg <= sweep_reg + (AW+1)'(1);
            end
            else
            begin
                sweep_reg <= '0;
            end
            if (state_reg == ST_SWEEP && state_next != ST_SWEEP)
            begin
                init_reg <= 1'b0;
            end
            first_reg <= (state_next != state_reg);
            if (state_reg == ST_IDLE && in_ch.valid && in_ch.ready)
            begin
                if (action_t'(in_ch.action) == ACT_CLEAR)
                begin
                    total_reg <= '0;
                    low_reg   <= 1'b0;
                    high_reg  <= 1'b0;
                end
                if (action_t'(in_ch.action) == ACT_ADD && in_ch.sample == '0)
                begin
                    low_reg <= 1'b1;
                end
            end
            if (state_reg == ST_MUL_HI)
            begin
                if (diff_reg < 0)
                begin
                    if (scale_reg != '0)
                    begin
                        low_reg <= 1'b1;
                    end
                end
                else if (bval >= 32'(eff_bins))
                begin
                    high_reg <= 1'b1;
                end
            end
            if (state_reg == ST_WR && total_reg != TOTAL_TOP)
            begin
                total_reg <= total_reg + SAMPLE_W'(1);
            end
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                act_reg    <= in_ch.action;
                sample_reg <= in_ch.sample;
                tf_reg     <= in_ch.tail_fraction;
                bin_reg    <= '0;
            end
            ST_LOG:
            begin
                diff_reg <= $signed({1'b0, lrsp.value}) - $signed({1'b0, log_min_reg});
            end
            ST_MUL_LO: prod_reg <= 49'(plo);
            ST_MUL_HI:
            begin
                if (diff_reg < 0)
                begin
                    bin_reg <= '0;
                end
                else if (bval >= 32'(eff_bins))
                begin
                    bin_reg <= top_bin;
                end
                else
                begin
                    bin_reg <= AW'(bval);
                end
            end
            ST_TGT_A:
            begin
                tgt_reg <= 73'(tf_reg) * 73'(total_reg[SAMPLE_W-1:24]);
                prod_reg <= 49'(tf_reg) * 49'(total_reg[23:0]);
                sum_reg <= '0;
            end
            ST_TGT_B:
            begin
                tgt_reg <= tgt_reg + 73'(prod_reg[48:24]);
            end
            ST_SCAN:
            begin
                if (!first_reg)
                begin
                    sum_reg <= sum_add;
                    bin_reg <= addr_reg;
                    if (sum_add < tgt_reg && addr_reg == '0)
                    begin
                        bin_reg <= '0;
                    end
                end
            end
            default: ;
        endcase
        if (state_reg == ST_DONE)
        begin
            out_bin_reg <= (act_reg == ACT_ADD || act_reg == ACT_QUERY)
                ? BIN_W'(bin_reg) : '0;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.bin_index      = out_bin_reg;
    assign out_ch.underflow_seen = low_reg;
    assign out_ch.overflow_seen  = high_reg;
    assign out_ch.total_count    = total_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("count write while idle");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg)
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/core/lbhp_ram.sv =====
`default_nettype none
module lbhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/lbhp_log2.sv =====
`default_nettype none
module lbhp_log2 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbhp_pkg::log_req_t req,
    output lbhp_pkg::log_rsp_t      rsp
);
    import lbhp_pkg::*;

    logic [31:0] mant_reg, mant_next;
    logic [15:0] frac_reg, frac_next;
    logic [5:0]  exp_reg, exp_next;
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] sq;
    logic [5:0]  lead;
    logic [SAMPLE_W-1:0] norm;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (req.sample[i])
            begin
                lead = 6'(i);
            end
        end
        norm = req.sample << (6'd47 - lead);
    end

    assign sq = 64'(mant_reg) * 64'(mant_reg);

    always_comb
    begin
        mant_next = mant_reg;
        frac_next = frac_reg;
        exp_next  = exp_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            mant_next = norm[SAMPLE_W-1 -: 32];
            frac_next = '0;
            exp_next  = lead;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sq[63])
            begin
                mant_next = sq[63:32];
            end
            else
            begin
                mant_next = sq[62:31];
            end
            frac_next = {frac_reg[14:0], sq[63]};
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        exp_reg  <= exp_next;
    end

    assign rsp.done  = busy_reg && step_reg == 5'd15;
    assign rsp.value = {exp_reg, frac_next};
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import lbhp_pkg::*;

    typedef struct packed {
        action_t             act;
        logic [SAMPLE_W-1:0] sample;
        logic [TF_W-1:0]     tf;
    } word_t;

    typedef struct packed {
        logic [BIN_W-1:0]    bin;
        logic                uf;
        logic                of;
        logic [SAMPLE_W-1:0] total;
    } hist_res_t;

    typedef struct packed {
        word_t     w;
        logic      typed;
        hist_res_t res;
    } row_t;

    localparam longint unsigned TOTAL_SAT = (64'd1 << SAMPLE_W) - 1;
    localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_BITS_DEF) - 1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbhp_in_if  in_ch();
    lbhp_out_if out_ch();

    log_binned_histogram_percentile DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    longint unsigned h_log_min;
    longint unsigned h_scale;
    longint unsigned h_bins;
    longint unsigned h_counts [MAX_BINS_DEF];
    longint unsigned h_total;
    logic h_low;
    logic h_high;

    hist_res_t expected_q [$];
    row_t      table_q [$];
    int        errors;
    int        burst_left;
    int unsigned rdy_cnt;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic longint unsigned log2_q616(input longint unsigned x);
        int e;
        longint unsigned m;
        longint unsigned sq;
        longint unsigned frac;
        e = 47;
        frac = 0;
        while (e > 0 && x[e] == 1'b0)
            e--;
        if (e >= 31)
            m = x >> (e - 31);
        else
            m = x << (31 - e);
        for (int i = 0; i < 16; i++)
        begin
            sq = m * m;
            frac = frac << 1;
            if (sq[63])
            begin
                frac = frac | 1;
                m = sq >> 32;
            end
            else
                m = sq >> 31;
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic longint unsigned eff_bins();
        if (h_bins == 0)
            return 1;
        if (h_bins > MAX_BINS_DEF)
            return MAX_BINS_DEF;
        return h_bins;
    endfunction

    function automatic void hist_clear();
        foreach (h_counts[i])
            h_counts[i] = 0;
        h_total = 0;
        h_low = 1'b0;
        h_high = 1'b0;
    endfunction

    function automatic hist_res_t hist_step(input word_t w);
        hist_res_t r;
        longint unsigned n;
        longint unsigned b;
        longint signed d;
        longint unsigned tgt;
        longint unsigned sum;
        longint unsigned bin;
        n = eff_bins();
        bin = 0;
        case (w.act)
            ACT_ADD:
            begin
                if (w.sample == 0)
                    h_low = 1'b1;
                else
                begin
                    d = longint'(log2_q616(w.sample)) - longint'(h_log_min);
                    if (d < 0)
                    begin
                        if (h_scale != 0)
                            h_low = 1'b1;
                    end
                    else
                    begin
                        b = (longint'(d) * h_scale) >> 32;
                        if (b >= n)
                        begin
                            bin = n - 1;
                            h_high = 1'b1;
                        end
                        else
                            bin = b;
                    end
                end
                if (h_counts[bin] < COUNT_SAT)
                    h_counts[bin]++;
                if (h_total < TOTAL_SAT)
                    h_total++;
            end
            ACT_QUERY:
            begin
                tgt = longint'(w.tf) * (h_total >> 24)
                    + ((longint'(w.tf) * (h_total & 64'hFFFFFF)) >> 24);
                sum = 0;
                for (longint i = n - 1; i >= 0; i--)
                begin
                    sum += h_counts[i];
                    if (sum >= tgt)
                    begin
                        bin = i;
                        break;
                    end
                end
            end
            ACT_CLEAR: hist_clear();
            default: ;
        endcase
        r.bin = bin[BIN_W-1:0];
        r.uf = h_low;
        r.of = h_high;
        r.total = h_total[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input action_t a, input longint unsigned s,
                                    input longint unsigned tf, input logic typed,
                                    input int bin, input logic uf, input logic of,
                                    input longint unsigned tot);
        row_t r;
        r.w.act = a;
        r.w.sample = s[SAMPLE_W-1:0];
        r.w.tf = tf[TF_W-1:0];
        r.typed = typed;
        r.res.bin = bin[BIN_W-1:0];
        r.res.uf = uf;
        r.res.of = of;
        r.res.total = tot[SAMPLE_W-1:0];
        table_q.push_back(r);
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int sel;
        longint unsigned s;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            w.act = ACT_ADD;
        else if (sel < 92)
            w.act = ACT_QUERY;
        else if (sel < 95)
            w.act = ACT_CLEAR;
        else
            w.act = ACT_NONE;
        s = {$urandom, $urandom};
        s = (s & TOTAL_SAT) >> $urandom_range(0, 48);
        if ($urandom_range(0, 40) == 0)
            s = 0;
        w.sample = s[SAMPLE_W-1:0];
        if ($urandom_range(0, 9) == 0)
            w.tf = TF_W'($urandom);
        else
            w.tf = TF_W'($urandom_range(0, 1 << 24));
        return w;
    endfunction

    task automatic send_word(input word_t w, input logic typed, input hist_res_t tres);
        hist_res_t p;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= w.act;
        in_ch.sample <= w.sample;
        in_ch.tail_fraction <= w.tf;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        p = hist_step(w);
        expected_q.push_back(typed ? tres : p);
        burst_left--;
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_LOG_MIN:   h_log_min = data & 32'h3FFFFF;
            CFG_BIN_SCALE: h_scale = data;
            CFG_BINS_USED: h_bins = data & 32'h7FF;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] lm,
                              input logic [CFG_DATA_W-1:0] sc,
                              input logic [CFG_DATA_W-1:0] nb);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // the clearing pass after reset may still be sweeping
        repeat (MAX_BINS_DEF + 40) @(posedge clk);
        write_cfg(CFG_LOG_MIN, lm);
        write_cfg(CFG_BIN_SCALE, sc);
        write_cfg(CFG_BINS_USED, nb);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver with its own stall pattern
    always @(posedge clk)
    begin
        hist_res_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("unexpected result word at %0t", $time);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.bin_index !== e.bin)
                    report("bin_index", out_ch.bin_index, e.bin);
                if (out_ch.underflow_seen !== e.uf)
                    report("underflow_seen", out_ch.underflow_seen, e.uf);
                if (out_ch.overflow_seen !== e.of)
                    report("overflow_seen", out_ch.overflow_seen, e.of);
                if (out_ch.total_count !== e.total)
                    report("total_count", out_ch.total_count, e.total);
            end
        end
        rdy_cnt <= rdy_cnt + 1;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (rdy_cnt[8:7] == 2'd0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 2) != 0);
    end

    initial
    begin
        #(12 * 6000000);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        longint unsigned lm;
        longint unsigned nb;
        longint unsigned sc;
        int span;
        hist_res_t none_res;
        errors = 0;
        burst_left = 0;
        rdy_cnt = 0;
        none_res = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LOG_MIN;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NONE;
        in_ch.sample = '0;
        in_ch.tail_fraction = '0;
        out_ch.ready = 1'b0;
        h_log_min = 0;
        h_scale = 65536;
        h_bins = 1024;
        hist_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_row(ACT_ADD, 0, 0, 1'b1, 0, 1'b1, 1'b0, 1);
        add_row(ACT_CLEAR, 0, 0, 1'b1, 0, 1'b0, 1'b0, 0);
        add_row(ACT_QUERY, 0, 0, 1'b1, 1023, 1'b0, 1'b0, 0);
        add_row(ACT_NONE, TOTAL_SAT, 25'h1FFFFFF, 1'b1, 0, 1'b0, 1'b0, 0);
        add_row(ACT_ADD, 1, 0, 1'b1, 0, 1'b0, 1'b0, 1);
        add_row(ACT_ADD, TOTAL_SAT, 0, 1'b1, 47, 1'b0, 1'b0, 2);
        add_row(ACT_ADD, 2, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 3, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 48'h8000_0000_0000, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 48'hAAAA_AAAA_AAAA, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 48'h5555_5555_5555, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 48'h0000_8000_0001, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_ADD, 1000, 0, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 1 << 24, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 25'h1FFFFFF, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 25'h0AAAAAA, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 25'h1555555, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 1 << 23, 1'b0, 0, 0, 0, 0);
        add_row(ACT_QUERY, 0, 1, 1'b0, 0, 0, 0, 0);
        add_row(ACT_NONE, 0, 0, 1'b0, 0, 0, 0, 0);

        // first config writes only once the clearing pass after reset is over
        set_config(0, 65536, 1024);
        foreach (table_q[i])
            send_word(table_q[i].w, table_q[i].typed, table_q[i].res);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_config(0, 32'h0010_0000, 1);
                1: set_config(32'h3FFFFF, 32'hFFFF_FFFF, 1024);
                2: set_config(8 << 16, 0, 300);
                3: set_config(2 << 16, 32'h0004_0000, 0);
                4: set_config(0, 32'h0100_0000, 2047);
                5: set_config($urandom, $urandom, $urandom);
                default:
                begin
                    lm = $urandom_range(0, 20);
                    lm = (lm << 16) | $urandom_range(0, 65535);
                    nb = $urandom_range(1, 1024);
                    span = 48 - int'(lm >> 16);
                    sc = (nb << 16) / span;
                    sc = sc * $urandom_range(80, 130) / 100;
                    if (sc > 32'hFFFF_FFFF)
                        sc = 32'hFFFF_FFFF;
                    set_config(lm, sc, nb);
                end
            endcase
            repeat (60)
                send_word(rand_word(), 1'b0, none_res);
        end

        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (MAX_BINS_DEF + 100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
